/* sv/sha1_pkg.sv */
`default_nettype none

package sha1_pkg;

  // One input word: absorb a message byte or finish the message.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } sha1_in_t;

  // One result word: a single 32-bit digest word and its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  // Input kind codes.
  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Number of digest words and the index of the last one.
  localparam int unsigned DIGEST_WORDS = 5;
  localparam logic [2:0]  LAST_INDEX   = 3'(DIGEST_WORDS - 1);

  // Rounds per block and the index of the last round.
  localparam int unsigned ROUNDS     = 80;
  localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);

  // Standard initial chaining value, word 0 first.
  localparam logic [0:4][31:0] SHA1_IV = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants for the four groups of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Padding marker byte.
  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

`default_nettype wire

/* sv/sha1_hash_engine.sv */
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    sha1_in_t  (kind, data_byte)
// out_     output     out_valid / out_ready  sha1_out_t (digest_word, word_index, last_word)
//
// An absorb word shifts its byte into the block; the 64th byte of a block starts a compression
// (80 rounds through the single round adder, then one chaining add).
// A finish word feeds 9 to 72 padding bytes at one per cycle, pausing for each of
// one or two compressions, and then presents the five digest words in turn.
// in_ready is high only in the idle state; out_valid only while the digest is shown.
// Reset (rst_n low, synchronous) restores the initial chaining value and a zero bit count.
module sha1_hash_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sha1_pkg::sha1_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sha1_pkg::sha1_out_t      out_data
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]   state_r;
  logic [6:0]   round_r;
  logic [2:0]   out_idx_r;
  logic         pad_first_r;
  logic         pad_late_r;
  logic         finishing_r;
  logic         done_r;
  logic [63:0]  bit_count_r;
  logic [31:0]  chain_r [DIGEST_WORDS];
  logic [511:0] blk_r;
  logic [63:0]  length_r;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;

  logic         in_acc;
  logic         out_acc;
  logic         absorb_en;
  logic         block_full;
  logic         len_phase;
  logic [2:0]   len_idx;
  logic [7:0]   pad_byte;
  logic [7:0]   feed_byte;
  logic         load_vars;
  logic [31:0]  w_cur;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;
  logic [31:0]  f_val;
  logic [31:0]  k_val;
  logic [31:0]  t_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Byte feed: either the incoming message byte or a generated padding byte.
  // A marker that lands in the last eight bytes of a block pushes the length
  // into the next block, so the rest of that block is zero.
  assign len_phase = !pad_first_r && !pad_late_r && (bit_count_r[8:6] == 3'b111);
  assign len_idx   = ~bit_count_r[5:3];
  always_comb begin
    priority if (pad_first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = length_r[{len_idx, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign absorb_en  = (in_acc && (in_data.kind == KIND_ABSORB)) || (state_r == ST_PAD);
  assign feed_byte  = (state_r == ST_PAD) ? pad_byte : in_data.data_byte;
  assign block_full = (bit_count_r[8:3] == 6'd63);
  assign load_vars  = absorb_en && block_full;

  // Message schedule taps on the 16-word window, oldest word at the top.
  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[511:480] ^ blk_r[447:416] ^ blk_r[255:224] ^ blk_r[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Round function and constant by round group.
  always_comb begin
    priority if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  // The shared round adder.
  assign t_sum = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_cur;

  // Sequencer and chaining state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_idx_r   <= '0;
      pad_first_r <= 1'b0;
      pad_late_r  <= 1'b0;
      finishing_r <= 1'b0;
      done_r      <= 1'b0;
      bit_count_r <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= SHA1_IV[i];
      end
    end else begin
      if (absorb_en) begin
        bit_count_r <= bit_count_r + 64'd8;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.kind == KIND_FINISH) begin
              pad_first_r <= 1'b1;
              pad_late_r  <= (bit_count_r[8:6] == 3'b111);
              finishing_r <= 1'b1;
              done_r      <= 1'b0;
              state_r     <= ST_PAD;
            end else if (block_full) begin
              finishing_r <= 1'b0;
              round_r     <= '0;
              state_r     <= ST_ROUND;
            end
          end
        end
        ST_PAD: begin
          pad_first_r <= 1'b0;
          if (block_full) begin
            pad_late_r <= 1'b0;
            done_r     <= len_phase;
            round_r    <= '0;
            state_r    <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          round_r <= round_r + 7'd1;
          if (round_r == LAST_ROUND) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          out_idx_r  <= '0;
          priority if (done_r) begin
            state_r <= ST_OUT;
          end else if (finishing_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (out_idx_r == LAST_INDEX) begin
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_r[i] <= SHA1_IV[i];
              end
              bit_count_r <= '0;
              finishing_r <= 1'b0;
              done_r      <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              out_idx_r <= out_idx_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Block window, working variables and captured length.
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.kind == KIND_FINISH)) begin
      length_r <= bit_count_r;
    end
    if (absorb_en) begin
      blk_r <= {blk_r[503:0], feed_byte};
    end else if (state_r == ST_ROUND) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (load_vars) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (state_r == ST_ROUND) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Digest words come straight from the chaining registers.
  assign out_data.digest_word = chain_r[out_idx_r];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == LAST_INDEX);

`ifndef SYNTH
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= LAST_ROUND))
    else $error("round counter ran past the last round");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while digest is shown");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.last_word) |=> (bit_count_r == 64'd0 && chain_r[0] == SHA1_IV[0]))
    else $error("engine did not restart after the last digest word");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == LAST_ROUND) |=> (state_r == ST_ADD))
    else $error("chaining add did not follow the last round");

  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_idx_r <= LAST_INDEX))
    else $error("digest word index out of range");
`endif

endmodule

`default_nettype wire

/* test/tb_sha1_hash_engine.sv */
module tb_sha1_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sha1_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sha1_out_t out_data;

  sha1_hash_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predicted hash state: chaining words, the partly filled block and the bit count.
  logic [31:0] hash_state[5];
  logic [31:0] msg_block[16];
  logic [63:0] msg_bits;

  // Digest words predicted but not yet seen on the output.
  sha1_out_t digest_q[$];

  int errors;
  int cycle_count;
  bit tx_idle;
  bit rx_idle;
  int rx_gap;
  int rx_hold_left;

  always #2 clk = ~clk;

  // Every mismatch goes through here; printing stops after PRINT_LIMIT mismatches, counting does not.
  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    errors++;
  endtask

  function automatic void restart_hash();
    for (int i = 0; i < 5; i++) begin
      hash_state[i] = SHA1_IV[i];
    end
    for (int i = 0; i < 16; i++) begin
      msg_block[i] = '0;
    end
    msg_bits = '0;
  endfunction

  // Eighty rounds over the current block, folded into the chaining words.
  function automatic void run_rounds();
    logic [31:0] sched[16];
    logic [31:0] a, b, c, d, e, f, k, wt, sum;
    for (int i = 0; i < 16; i++) begin
      sched[i] = msg_block[i];
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = sched[r];
      end else begin
        wt = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15] ^ sched[r & 15];
        wt = {wt[30:0], wt[31]};
        sched[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // Packs one byte big-endian into the block and compresses a full block.
  function automatic void take_byte(input logic [7:0] value);
    int pos;
    pos = int'(msg_bits[8:3]);
    if ((pos & 3) == 0) begin
      msg_block[pos >> 2] = {value, 24'h0};
    end else begin
      msg_block[pos >> 2] |= 32'(value) << (24 - 8 * (pos & 3));
    end
    msg_bits += 64'd8;
    if (pos == 63) begin
      run_rounds();
    end
  endfunction

  // Pads the message, queues the five digest words and starts a new message.
  function automatic void close_message();
    logic [63:0] length;
    sha1_out_t   word;
    length = msg_bits;
    take_byte(PAD_MARK);
    while (msg_bits[8:3] != 6'd56) begin
      take_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      take_byte(length[63 - 8 * i -: 8]);
    end
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      word.digest_word = hash_state[i];
      word.word_index  = 3'(i);
      word.last_word   = (3'(i) == LAST_INDEX);
      digest_q.push_back(word);
    end
    restart_hash();
  endfunction

  // Offers one word, after a random gap if tx_idle is set, and predicts its effect once accepted.
  task automatic send_word(input logic kind, input logic [7:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, data_byte: value};
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_ABSORB) begin
      take_byte(value);
    end else begin
      close_message();
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_digests_done();
    idle_input();
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Empty messages, back to back, with the ignored data byte at both extremes.
  task automatic test_empty_messages();
    send_word(KIND_FINISH, 8'h00);
    send_word(KIND_FINISH, 8'hFF);
    wait_digests_done();
  endtask

  // Short messages: the classic three letters and single bytes at both extremes.
  task automatic test_short_messages();
    send_word(KIND_ABSORB, 8'h61);
    send_word(KIND_ABSORB, 8'h62);
    send_word(KIND_ABSORB, 8'h63);
    send_word(KIND_FINISH, 8'h00);
    send_word(KIND_ABSORB, 8'hFF);
    send_word(KIND_FINISH, 8'hA5);
    send_word(KIND_ABSORB, 8'h00);
    send_word(KIND_FINISH, 8'h5A);
    wait_digests_done();
  endtask

  // The receiver stalls for a long stretch while words keep coming, so the
  // engine holds its digest and stops taking input.
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_hold_left = 400;
    for (int m = 0; m < 2; m++) begin
      repeat (8) send_word(KIND_ABSORB, 8'($urandom_range(0, 255)));
      send_word(KIND_FINISH, 8'($urandom_range(0, 255)));
    end
    wait_digests_done();
  endtask

  // Random messages; the first puts the padding marker where the length field
  // starts, so padding spills into a second block, the second fills a block
  // exactly, and later ones are mostly short with an occasional length that
  // needs a second compression.
  task automatic test_random_messages();
    int sent;
    int msgs;
    int len;
    sent = 0;
    msgs = 0;
    while (sent < 100 || msgs < 3) begin
      case (msgs)
        0: len = 56;
        1: len = 64;
        default: len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 72)
                                                    : $urandom_range(0, 20);
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat (len) send_word(KIND_ABSORB, 8'($urandom_range(0, 255)));
      send_word(KIND_FINISH, 8'($urandom_range(0, 255)));
      sent += len + 1;
      msgs++;
    end
    wait_digests_done();
  endtask

  // Receiver side: out_ready drops for the drawn gap after each word and for
  // any long hold that a test asks for.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checks each accepted digest word against the oldest prediction.
  always @(posedge clk) begin
    sha1_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d",
                                  out_data.digest_word, out_data.word_index));
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          report_mismatch($sformatf("word %0d: digest_word %h, expected %h", want.word_index,
                                    out_data.digest_word, want.digest_word));
        end
        if (out_data.word_index !== want.word_index) begin
          report_mismatch($sformatf("word_index %0d, expected %0d",
                                    out_data.word_index, want.word_index));
        end
        if (out_data.last_word !== want.last_word) begin
          report_mismatch($sformatf("word %0d: last_word %b, expected %b", want.word_index,
                                    out_data.last_word, want.last_word));
        end
      end
      rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_gap       = 0;
    rx_hold_left = 0;
    restart_hash();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_messages();
    test_short_messages();
    test_output_backpressure();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_random_messages();

    // Let any trailing activity settle before the verdict.
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sha1_pkg.sv
sv/sha1_hash_engine.sv
test/tb_sha1_hash_engine.sv
